// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, active in every cycle including reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/pmvd_pkg.sv
// Types, constants and arithmetic helpers of the precoder matrix-vector detector.
`timescale 1ns / 1ps
package pmvd_pkg;

    // Fixed field widths
    localparam int SC_W    = 10;
    localparam int UIDX_W  = 2;
    localparam int ANT_W   = 4;
    localparam int DATA_W  = 16;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = 32;
    localparam int PAIR_W  = 33;
    localparam int ACC_W   = 40;
    localparam int EXT_W   = ACC_W + 1;
    localparam int SHIFT_W = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic signed [EXT_W-1:0] SAT_MAX = 41'sd32767;
    localparam logic signed [EXT_W-1:0] SAT_MIN = -41'sd32768;

    // Side information travelling with a sample down the MAC pipeline
    typedef struct packed {
        logic            contrib;
        logic            last;
        logic [SC_W-1:0] sc;
    } t_meta;

    // Hand-over of finished sums from the MAC to the output drain
    typedef struct packed {
        logic            load;
        logic [SC_W-1:0] sc;
    } t_bank_req;

    typedef struct packed {
        logic active;
        logic bank_free;
    } t_drain_stat;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     clip;
    } t_fin;

    // Exact 16x16 signed product
    function automatic logic signed [PROD_W-1:0] mul16(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // Round half up, arithmetic shift right, saturate to 16 bits
    function automatic t_fin finish(
        input logic signed [ACC_W-1:0] acc,
        input logic [SHIFT_W-1:0]      s
    );
        logic signed [EXT_W-1:0] ext;
        logic        [EXT_W-1:0] half;
        logic signed [EXT_W-1:0] sum;
        logic signed [EXT_W-1:0] sh;
        t_fin                    f;
        ext  = EXT_W'(acc);
        half = (EXT_W'(1) << s) >> 1;
        sum  = ext + $signed(half);
        sh   = sum >>> s;
        if (sh > SAT_MAX) begin
            f.value = SAT_MAX[DATA_W-1:0];
            f.clip  = 1'b1;
        end else if (sh < SAT_MIN) begin
            f.value = SAT_MIN[DATA_W-1:0];
            f.clip  = 1'b1;
        end else begin
            f.value = sh[DATA_W-1:0];
            f.clip  = 1'b0;
        end
        return f;
    endfunction

endpackage

// File: hdl/pmvd_coef_store.sv
// Coefficient memory: one row per subcarrier and antenna, one lane per user.
`timescale 1ns / 1ps
module pmvd_coef_store #(
    parameter int NUM_USERS = 4,
    parameter int ROWS      = 16384,
    parameter int ROW_W     = 14
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [ROW_W-1:0]                           i_wr_addr,
    input  logic [NUM_USERS-1:0]                       i_wr_lane,
    input  logic [pmvd_pkg::COEF_W-1:0]                i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [ROW_W-1:0]                           i_rd_addr,
    output logic [NUM_USERS-1:0][pmvd_pkg::COEF_W-1:0] o_rd_data
);

    logic [NUM_USERS-1:0][pmvd_pkg::COEF_W-1:0] r_mem [ROWS];
    logic [NUM_USERS-1:0][pmvd_pkg::COEF_W-1:0] r_rd_data;

    // Lane write, registered row read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int u = 0; u < NUM_USERS; u++) begin
                if (i_wr_lane[u]) begin
                    r_mem[i_wr_addr][u] <= i_wr_data;
                end
            end
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/pmvd_mac.sv
// Complex multiply-accumulate pipeline, one lane per user.
`timescale 1ns / 1ps
module pmvd_mac #(
    parameter int NUM_USERS = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_adv,
    input  logic                                      i_in_v,
    input  pmvd_pkg::t_meta                           i_in_meta,
    input  logic signed [pmvd_pkg::DATA_W-1:0]        i_in_re,
    input  logic signed [pmvd_pkg::DATA_W-1:0]        i_in_im,
    input  logic [NUM_USERS-1:0][pmvd_pkg::COEF_W-1:0] i_coef,
    output logic                                      o_last_pending,
    output pmvd_pkg::t_bank_req                       o_bank_req,
    output logic [NUM_USERS-1:0][pmvd_pkg::ACC_W-1:0] o_sum_re,
    output logic [NUM_USERS-1:0][pmvd_pkg::ACC_W-1:0] o_sum_im
);

    localparam int DW = pmvd_pkg::DATA_W;
    localparam int PW = pmvd_pkg::PROD_W;
    localparam int QW = pmvd_pkg::PAIR_W;
    localparam int AW = pmvd_pkg::ACC_W;

    logic                 r_s1_v, r_s2_v, r_s3_v;
    pmvd_pkg::t_meta      r_s1_meta, r_s2_meta, r_s3_meta;
    logic signed [DW-1:0] r_s1_re, r_s1_im;
    logic signed [PW-1:0] r_p_rr [NUM_USERS];
    logic signed [PW-1:0] r_p_ii [NUM_USERS];
    logic signed [PW-1:0] r_p_ri [NUM_USERS];
    logic signed [PW-1:0] r_p_ir [NUM_USERS];
    logic signed [QW-1:0] r_pr [NUM_USERS];
    logic signed [QW-1:0] r_pi [NUM_USERS];
    logic signed [AW-1:0] r_acc_re [NUM_USERS];
    logic signed [AW-1:0] r_acc_im [NUM_USERS];
    logic signed [AW-1:0] sum_re [NUM_USERS];
    logic signed [AW-1:0] sum_im [NUM_USERS];
    logic                 s3_take;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_in_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Stage 1: sample, coefficients arrive from the store
    // Stage 2: four partial products per user
    // Stage 3: combined complex product
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_meta <= i_in_meta;
            r_s1_re   <= i_in_re;
            r_s1_im   <= i_in_im;
            r_s2_meta <= r_s1_meta;
            r_s3_meta <= r_s2_meta;
            for (int u = 0; u < NUM_USERS; u++) begin
                r_p_rr[u] <= pmvd_pkg::mul16($signed(i_coef[u][DW-1:0]), r_s1_re);
                r_p_ii[u] <= pmvd_pkg::mul16($signed(i_coef[u][2*DW-1:DW]), r_s1_im);
                r_p_ri[u] <= pmvd_pkg::mul16($signed(i_coef[u][DW-1:0]), r_s1_im);
                r_p_ir[u] <= pmvd_pkg::mul16($signed(i_coef[u][2*DW-1:DW]), r_s1_re);
                r_pr[u]   <= QW'(r_p_rr[u]) - QW'(r_p_ii[u]);
                r_pi[u]   <= QW'(r_p_ri[u]) + QW'(r_p_ir[u]);
            end
        end
    end

    // Running sums including the product now in stage 3
    always_comb begin
        for (int u = 0; u < NUM_USERS; u++) begin
            if (r_s3_meta.contrib) begin
                sum_re[u] = r_acc_re[u] + AW'(r_pr[u]);
                sum_im[u] = r_acc_im[u] + AW'(r_pi[u]);
            end else begin
                sum_re[u] = r_acc_re[u];
                sum_im[u] = r_acc_im[u];
            end
            o_sum_re[u] = sum_re[u];
            o_sum_im[u] = sum_im[u];
        end
    end

    assign s3_take = i_adv && r_s3_v;

    // Accumulators: add, or clear on the end of a vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < NUM_USERS; u++) begin
                r_acc_re[u] <= '0;
                r_acc_im[u] <= '0;
            end
        end else if (s3_take) begin
            for (int u = 0; u < NUM_USERS; u++) begin
                if (r_s3_meta.last) begin
                    r_acc_re[u] <= '0;
                    r_acc_im[u] <= '0;
                end else begin
                    r_acc_re[u] <= sum_re[u];
                    r_acc_im[u] <= sum_im[u];
                end
            end
        end
    end

    assign o_last_pending  = r_s3_v && r_s3_meta.last;
    assign o_bank_req.load = s3_take && r_s3_meta.last;
    assign o_bank_req.sc   = r_s3_meta.sc;

endmodule

// File: hdl/pmvd_drain.sv
// Result bank and output stage: rounds, saturates and sends one user per cycle while i_stall does not hold it.
`timescale 1ns / 1ps
module pmvd_drain #(
    parameter int NUM_USERS = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  pmvd_pkg::t_bank_req                       i_bank_req,
    input  logic [NUM_USERS-1:0][pmvd_pkg::ACC_W-1:0] i_sum_re,
    input  logic [NUM_USERS-1:0][pmvd_pkg::ACC_W-1:0] i_sum_im,
    input  logic [pmvd_pkg::SHIFT_W-1:0]              i_shift,
    input  logic                                      i_stall,
    output pmvd_pkg::t_drain_stat                     o_stat,
    output logic                                      o_valid,
    output logic [pmvd_pkg::UIDX_W-1:0]               o_out_user,
    output logic [pmvd_pkg::SC_W-1:0]                 o_out_subcarrier,
    output logic signed [pmvd_pkg::DATA_W-1:0]        o_out_real,
    output logic signed [pmvd_pkg::DATA_W-1:0]        o_out_imag,
    output logic                                      o_clipped,
    output logic                                      o_last_user
);

    localparam int USER_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam logic [USER_W-1:0] LAST_USER = USER_W'(NUM_USERS - 1);

    logic signed [pmvd_pkg::ACC_W-1:0] r_bank_re [NUM_USERS];
    logic signed [pmvd_pkg::ACC_W-1:0] r_bank_im [NUM_USERS];
    logic [pmvd_pkg::SC_W-1:0]         r_bank_sc;
    logic                              r_active;
    logic [USER_W-1:0]                 r_user;
    logic                              r_out_v;
    logic [pmvd_pkg::UIDX_W-1:0]       r_out_user;
    logic [pmvd_pkg::SC_W-1:0]         r_out_sc;
    logic signed [pmvd_pkg::DATA_W-1:0] r_out_re, r_out_im;
    logic                              r_out_clip, r_out_last;
    logic                              drain_go;
    pmvd_pkg::t_fin                    fin_re, fin_im;
    logic [31:0]                       user_ext;

    assign drain_go         = r_active && (!r_out_v || !i_stall);
    assign o_stat.active    = r_active;
    assign o_stat.bank_free = !r_active || (drain_go && (r_user == LAST_USER));

    // Result bank, loaded once per vector
    always_ff @(posedge i_clk) begin
        if (i_bank_req.load) begin
            for (int u = 0; u < NUM_USERS; u++) begin
                r_bank_re[u] <= $signed(i_sum_re[u]);
                r_bank_im[u] <= $signed(i_sum_im[u]);
            end
            r_bank_sc <= i_bank_req.sc;
        end
    end

    // User sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_user   <= '0;
        end else if (i_bank_req.load) begin
            r_active <= 1'b1;
            r_user   <= '0;
        end else if (drain_go) begin
            if (r_user == LAST_USER) begin
                r_active <= 1'b0;
            end
            r_user <= r_user + USER_W'(1);
        end
    end

    // Rounding and saturation of the current user
    always_comb begin
        fin_re   = pmvd_pkg::finish(r_bank_re[r_user], i_shift);
        fin_im   = pmvd_pkg::finish(r_bank_im[r_user], i_shift);
        user_ext = 32'(r_user);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (drain_go) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_go) begin
            r_out_user <= user_ext[pmvd_pkg::UIDX_W-1:0];
            r_out_sc   <= r_bank_sc;
            r_out_re   <= fin_re.value;
            r_out_im   <= fin_im.value;
            r_out_clip <= fin_re.clip || fin_im.clip;
            r_out_last <= (r_user == LAST_USER);
        end
    end

    assign o_valid          = r_out_v;
    assign o_out_user       = r_out_user;
    assign o_out_subcarrier = r_out_sc;
    assign o_out_real       = r_out_re;
    assign o_out_imag       = r_out_im;
    assign o_clipped        = r_out_clip;
    assign o_last_user      = r_out_last;

endmodule

// File: hdl/precoder_matrix_vector_detect.sv
// Top level of the precoder matrix-vector detector.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   Input channel (i_valid / o_stall): cmd 0 writes one complex coefficient
//   into the row of (subcarrier, antenna) at the lane of user_index; cmd 1
//   brings one antenna sample, multiplied with every user's coefficient and
//   added into per-user 40-bit accumulators. A sample with last_antenna set
//   closes the vector: one result per user follows, in user order.
//   Output channel (o_valid / i_stall): one result per user per vector, registered.
//   Configuration channel (i_cfg_valid / o_cfg_ready): output_shift, always ready;
//   the user must see that it is written only while the block is idle (not enforced).
// Throughput: one request per cycle while o_stall is low. The coefficient store is read
//   once per in-range sample (one row holds all users), multipliers and adders are pipelined.
// Path: a closing sample passes the MAC stages, the result bank and the output register
//   before its first result is valid; the other users follow one per cycle unless i_stall holds.
// Stall: a closing sample waits in the last MAC stage while the result bank
//   still drains the previous vector; the input then stalls. The output
//   register holds under i_stall and the bank drains no further.
// Reset: accumulators clear, output_shift returns to 14; the coefficient
//   store keeps its contents and is undefined until written.
module precoder_matrix_vector_detect #(
    parameter int NUM_ANTENNAS    = 16,
    parameter int NUM_USERS       = 4,
    parameter int NUM_SUBCARRIERS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [pmvd_pkg::SC_W-1:0]           i_subcarrier,
    input  logic [pmvd_pkg::UIDX_W-1:0]         i_user_index,
    input  logic [pmvd_pkg::ANT_W-1:0]          i_antenna,
    input  logic signed [pmvd_pkg::DATA_W-1:0]  i_real_part,
    input  logic signed [pmvd_pkg::DATA_W-1:0]  i_imag_part,
    input  logic                                i_last_antenna,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [pmvd_pkg::UIDX_W-1:0]         o_out_user,
    output logic [pmvd_pkg::SC_W-1:0]           o_out_subcarrier,
    output logic signed [pmvd_pkg::DATA_W-1:0]  o_out_real,
    output logic signed [pmvd_pkg::DATA_W-1:0]  o_out_imag,
    output logic                                o_clipped,
    output logic                                o_last_user,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pmvd_pkg::SHIFT_W-1:0]        i_cfg_data
);

    localparam int ROWS  = NUM_SUBCARRIERS * NUM_ANTENNAS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [pmvd_pkg::SHIFT_W-1:0]               r_shift;
    logic                                       adv;
    logic                                       accept;
    logic                                       sc_ok, ant_ok, user_ok;
    logic                                       wr_en, sample_in;
    logic [31:0]                                row_full;
    logic [ROW_W-1:0]                           row_addr;
    logic [NUM_USERS-1:0]                       wr_lane;
    logic [NUM_USERS-1:0][pmvd_pkg::COEF_W-1:0] coef;
    pmvd_pkg::t_meta                            in_meta;
    logic                                       mac_last_pending;
    pmvd_pkg::t_bank_req                        bank_req;
    pmvd_pkg::t_drain_stat                      drain_stat;
    logic [NUM_USERS-1:0][pmvd_pkg::ACC_W-1:0]  sum_re, sum_im;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= pmvd_pkg::SHIFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shift <= i_cfg_data;
        end
    end

    // Pipeline advances unless a closing sample waits for the result bank
    assign adv     = !(mac_last_pending && !drain_stat.bank_free);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // Request decode and row address
    always_comb begin
        sc_ok    = 32'(i_subcarrier) < NUM_SUBCARRIERS;
        ant_ok   = 32'(i_antenna) < NUM_ANTENNAS;
        user_ok  = 32'(i_user_index) < NUM_USERS;
        row_full = 32'(i_subcarrier) * 32'(NUM_ANTENNAS) + 32'(i_antenna);
        row_addr = row_full[ROW_W-1:0];
        for (int u = 0; u < NUM_USERS; u++) begin
            wr_lane[u] = (32'(i_user_index) == u);
        end
        wr_en = accept && (i_cmd == pmvd_pkg::CMD_WRITE) && sc_ok && ant_ok && user_ok;
        sample_in       = accept && (i_cmd == pmvd_pkg::CMD_SAMPLE);
        in_meta.contrib = sc_ok && ant_ok;
        in_meta.last    = i_last_antenna;
        in_meta.sc      = i_subcarrier;
    end

    pmvd_coef_store #(
        .NUM_USERS (NUM_USERS),
        .ROWS      (ROWS),
        .ROW_W     (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (row_addr),
        .i_wr_lane (wr_lane),
        .i_wr_data ({i_imag_part, i_real_part}),
        .i_rd_en   (sample_in && in_meta.contrib),
        .i_rd_addr (row_addr),
        .o_rd_data (coef)
    );

    pmvd_mac #(
        .NUM_USERS (NUM_USERS)
    ) u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_in_v         (sample_in),
        .i_in_meta      (in_meta),
        .i_in_re        (i_real_part),
        .i_in_im        (i_imag_part),
        .i_coef         (coef),
        .o_last_pending (mac_last_pending),
        .o_bank_req     (bank_req),
        .o_sum_re       (sum_re),
        .o_sum_im       (sum_im)
    );

    pmvd_drain #(
        .NUM_USERS (NUM_USERS)
    ) u_drain (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bank_req       (bank_req),
        .i_sum_re         (sum_re),
        .i_sum_im         (sum_im),
        .i_shift          (r_shift),
        .i_stall          (i_stall),
        .o_stat           (drain_stat),
        .o_valid          (o_valid),
        .o_out_user       (o_out_user),
        .o_out_subcarrier (o_out_subcarrier),
        .o_out_real       (o_out_real),
        .o_out_imag       (o_out_imag),
        .o_clipped        (o_clipped),
        .o_last_user      (o_last_user)
    );

    // Checks
    `ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_stall |-> (mac_last_pending && drain_stat.active), "input stalled without a closing sample waiting on a busy bank")
    `ASSERT_RST(a_bank_drains, i_clk, i_rst_n, bank_req.load |=> drain_stat.active, "result bank loaded but drain not running")
    `ASSERT_RST(a_vector_contig, i_clk, i_rst_n, (o_valid && !i_stall && !o_last_user) |=> (o_valid && (o_out_subcarrier == $past(o_out_subcarrier))), "results of one vector not contiguous")

endmodule
